FILE: rtl/core/c_subset_lexer_assert.svh
// ----------------------------------------------------------------------------
// c_subset_lexer_assert.svh
// Assertion macros for the lexer. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef C_SUBSET_LEXER_ASSERT_SVH
`define C_SUBSET_LEXER_ASSERT_SVH

// Same-cycle implication.
`define CLX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CLX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/clx_pkg.sv
// ----------------------------------------------------------------------------
// clx_pkg
// Token codes, result record, character classes and keyword constants.
// ----------------------------------------------------------------------------
package clx_pkg;

  localparam int CLX_TOKEN_LIMIT = 1024;
  localparam int CLX_NAME_LIMIT  = 9;

  // Result queue between scanner and output stage
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [4:0] {
    TK_FOR    = 5'd0,
    TK_WHILE  = 5'd1,
    TK_INT    = 5'd2,
    TK_RETURN = 5'd3,
    TK_IDENT  = 5'd4,
    TK_LIT    = 5'd5,
    TK_PP     = 5'd6,
    TK_PLUS   = 5'd7,
    TK_MINUS  = 5'd8,
    TK_STAR   = 5'd9,
    TK_AMP    = 5'd10,
    TK_ASSIGN = 5'd11,
    TK_LT     = 5'd12,
    TK_LPAREN = 5'd13,
    TK_RPAREN = 5'd14,
    TK_LBRACE = 5'd15,
    TK_RBRACE = 5'd16,
    TK_SEMI   = 5'd17,
    TK_COMMA  = 5'd18,
    TK_END    = 5'd19,
    TK_BAD    = 5'd20,
    TK_FULL   = 5'd21
  } token_kind_t;

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_WORD   = 5'b00010,
    MODE_DIGITS = 5'b00100,
    MODE_PLUS   = 5'b01000,
    MODE_DRAIN  = 5'b10000
  } scan_mode_t;

  // Keywords packed first byte lowest
  localparam logic [63:0] KW_FOR    = 64'h0000_0000_0072_6f66;
  localparam logic [63:0] KW_WHILE  = 64'h0000_0065_6c69_6877;
  localparam logic [63:0] KW_INT    = 64'h0000_0000_0074_6e69;
  localparam logic [63:0] KW_RETURN = 64'h0000_6e72_7574_6572;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_PLUS = 8'h2b;

  typedef struct packed {
    token_kind_t  kind;
    logic [9:0]   index;
    logic [31:0]  value;
    logic         ovf;
    logic [63:0]  text;
    logic [3:0]   len;
    logic [7:0]   bad;
    logic         last;
  } clx_rec_t;

  // Up to two records written into the queue per accepted byte
  typedef struct packed {
    logic [1:0] n;
    clx_rec_t   r0;
    clx_rec_t   r1;
  } clx_push_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  // Single-character operators; TK_BAD when the byte is none of them
  function automatic token_kind_t op_kind(input logic [7:0] c);
    token_kind_t k;
    unique case (c)
      8'h2d:   k = TK_MINUS;
      8'h2a:   k = TK_STAR;
      8'h26:   k = TK_AMP;
      8'h3d:   k = TK_ASSIGN;
      8'h3c:   k = TK_LT;
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h7b:   k = TK_LBRACE;
      8'h7d:   k = TK_RBRACE;
      8'h3b:   k = TK_SEMI;
      8'h2c:   k = TK_COMMA;
      default: k = TK_BAD;
    endcase
    return k;
  endfunction

  function automatic clx_rec_t mk_rec(input token_kind_t k, input logic [9:0] idx,
                                      input logic [31:0] v, input logic o,
                                      input logic [63:0] t, input logic [3:0] l,
                                      input logic [7:0] b);
    clx_rec_t r;
    r.kind  = k;
    r.index = idx;
    r.value = v;
    r.ovf   = o;
    r.text  = t;
    r.len   = l;
    r.bad   = b;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/core/c_subset_lexer.sv
// ----------------------------------------------------------------------------
// c_subset_lexer
// Streaming lexer for a small C subset: one source byte in and one token
// word out per cycle when not stalled, zero byte ends each string.
// ----------------------------------------------------------------------------
// The lexer takes one byte per clock while in_stall is low. Identifiers,
// literals and '+' finish on the byte after them, so a byte yields zero, one
// or two tokens; tokens leave at one per clock, unless the sink stalls,
// through a four-entry queue and an output register. in_stall rises only
// when the queue has fewer than two free entries, i.e. when tokens arrive
// faster than one per cycle for a while or the sink stalls.
module c_subset_lexer import clx_pkg::*; #(
  parameter int TOKEN_LIMIT = CLX_TOKEN_LIMIT,
  parameter int NAME_LIMIT  = CLX_NAME_LIMIT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_token_kind,
  output logic [9:0]         out_token_index,
  output logic signed [31:0] out_literal_value,
  output logic               out_literal_overflow,
  output logic [63:0]        out_name_text,
  output logic [3:0]         out_name_length,
  output logic [7:0]         out_bad_char,
  output logic               out_last_of_run
);

  clx_push_t push;
  logic      room, head_valid, pop;
  clx_rec_t  head, rec;

  clx_front #(
    .TOKEN_LIMIT (TOKEN_LIMIT),
    .NAME_LIMIT  (NAME_LIMIT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .room_i       (room),
    .push_o       (push)
  );

  clx_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (push),
    .pop_i        (pop),
    .room_o       (room),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  clx_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rec_o        (rec)
  );

  assign out_token_kind       = rec.kind;
  assign out_token_index      = rec.index;
  assign out_literal_value    = $signed(rec.value);
  assign out_literal_overflow = rec.ovf;
  assign out_name_text        = rec.text;
  assign out_name_length      = rec.len;
  assign out_bad_char         = rec.bad;
  assign out_last_of_run      = rec.last;

endmodule

FILE: rtl/core/clx_front.sv
// ----------------------------------------------------------------------------
// clx_front
// Scanner: takes one source byte per cycle while the queue has room, tracks
// the token being built and produces up to two result records for the queue.
// ----------------------------------------------------------------------------
module clx_front import clx_pkg::*; #(
  parameter int TOKEN_LIMIT = CLX_TOKEN_LIMIT,
  parameter int NAME_LIMIT  = CLX_NAME_LIMIT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       room_i,
  output clx_push_t  push_o
);

  localparam int CW   = $clog2(TOKEN_LIMIT + 1);
  localparam int XW   = (CW > 10) ? CW : 10;
  localparam logic [CW-1:0] LIM = CW'(TOKEN_LIMIT);
  localparam int KEEP = (NAME_LIMIT - 1 > 8) ? 8 : NAME_LIMIT - 1;
  localparam logic [63:0] NAME_MASK = (KEEP >= 8) ? '1 : ((64'd1 << (8 * KEEP)) - 64'd1);
  localparam logic [3:0]  KEEP_LEN  = 4'(KEEP);

  function automatic logic [9:0] sat_index(input logic [CW-1:0] c);
    logic [XW-1:0] cx;
    cx = XW'(c);
    if (cx > XW'(1023)) return 10'd1023;
    return cx[9:0];
  endfunction

  scan_mode_t    mode_r, mode_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [63:0]   buf_r, buf_nxt;
  logic [3:0]    fill_r, fill_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic          ovf_r, ovf_nxt;

  logic          accept;
  logic [7:0]    c;
  logic [35:0]   acc_step;
  token_kind_t   word_kind;
  logic          kw_hit;
  token_kind_t   op_k;

  logic          pend, done, va, vb;
  token_kind_t   pend_kind;
  logic [31:0]   pend_val;
  logic          pend_ovf;
  logic [63:0]   pend_text;
  logic [3:0]    pend_len;
  clx_rec_t      rec_a, rec_b;

  assign c        = in_char_code;
  assign accept   = in_valid && room_i;
  assign in_stall = !room_i;
  assign acc_step = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {32'd0, c[3:0]};
  assign op_k     = op_kind(c);

  always_comb begin
    kw_hit    = 1'b1;
    word_kind = TK_IDENT;
    if (fill_r == 4'd3 && buf_r == KW_FOR)         word_kind = TK_FOR;
    else if (fill_r == 4'd5 && buf_r == KW_WHILE)  word_kind = TK_WHILE;
    else if (fill_r == 4'd3 && buf_r == KW_INT)    word_kind = TK_INT;
    else if (fill_r == 4'd6 && buf_r == KW_RETURN) word_kind = TK_RETURN;
    else                                           kw_hit = 1'b0;
  end

  always_comb begin
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    buf_nxt   = buf_r;
    fill_nxt  = fill_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    pend      = 1'b0;
    done      = 1'b0;
    va        = 1'b0;
    vb        = 1'b0;
    pend_kind = TK_IDENT;
    pend_val  = '0;
    pend_ovf  = 1'b0;
    pend_text = '0;
    pend_len  = '0;
    rec_a     = '0;
    rec_b     = '0;

    // Token waiting for its first non-member byte
    unique case (mode_r)
      MODE_WORD: begin
        if (is_letter(c) || is_digit(c)) begin
          if (fill_r < 4'd8) buf_nxt[8 * fill_r[2:0] +: 8] = c;
          if (fill_r < 4'd9) fill_nxt = fill_r + 4'd1;
          done = 1'b1;
        end else begin
          pend      = 1'b1;
          pend_kind = word_kind;
          if (!kw_hit) begin
            pend_text = buf_r & NAME_MASK;
            pend_len  = (fill_r < KEEP_LEN) ? fill_r : KEEP_LEN;
          end
        end
      end
      MODE_DIGITS: begin
        if (is_digit(c)) begin
          acc_nxt = acc_step[31:0];
          ovf_nxt = ovf_r | (acc_step[35:31] != 5'd0);
          done    = 1'b1;
        end else begin
          pend      = 1'b1;
          pend_kind = TK_LIT;
          pend_val  = acc_r;
          pend_ovf  = ovf_r;
        end
      end
      MODE_PLUS: begin
        pend      = 1'b1;
        done      = (c == CH_PLUS);
        pend_kind = (c == CH_PLUS) ? TK_PP : TK_PLUS;
      end
      MODE_IDLE, MODE_DRAIN: ;
      default: mode_nxt = MODE_IDLE;
    endcase

    if (pend) begin
      va = 1'b1;
      if (cnt_nxt >= LIM) begin
        rec_a    = mk_rec(TK_FULL, sat_index(cnt_nxt), '0, 1'b0, '0, '0, '0);
        mode_nxt = MODE_DRAIN;
      end else begin
        rec_a    = mk_rec(pend_kind, sat_index(cnt_nxt), pend_val, pend_ovf,
                          pend_text, pend_len, '0);
        cnt_nxt  = cnt_nxt + CW'(1);
        mode_nxt = MODE_IDLE;
      end
    end

    if (!done) begin
      if (mode_nxt == MODE_DRAIN) begin
        if (c == CH_NUL) begin
          cnt_nxt  = '0;
          mode_nxt = MODE_IDLE;
        end
      end else begin
        priority if (c == CH_NUL) begin
          vb = 1'b1;
          if (cnt_nxt >= LIM)
            rec_b = mk_rec(TK_FULL, sat_index(cnt_nxt), '0, 1'b0, '0, '0, '0);
          else
            rec_b = mk_rec(TK_END, sat_index(cnt_nxt), '0, 1'b0, '0, '0, '0);
          cnt_nxt  = '0;
          mode_nxt = MODE_IDLE;
        end else if (is_space(c)) begin
          mode_nxt = MODE_IDLE;
        end else if (is_letter(c)) begin
          buf_nxt  = {56'd0, c};
          fill_nxt = 4'd1;
          mode_nxt = MODE_WORD;
        end else if (is_digit(c)) begin
          acc_nxt  = {28'd0, c[3:0]};
          ovf_nxt  = 1'b0;
          mode_nxt = MODE_DIGITS;
        end else if (c == CH_PLUS) begin
          mode_nxt = MODE_PLUS;
        end else if (op_k != TK_BAD) begin
          vb = 1'b1;
          if (cnt_nxt >= LIM) begin
            rec_b    = mk_rec(TK_FULL, sat_index(cnt_nxt), '0, 1'b0, '0, '0, '0);
            mode_nxt = MODE_DRAIN;
          end else begin
            rec_b    = mk_rec(op_k, sat_index(cnt_nxt), '0, 1'b0, '0, '0, '0);
            cnt_nxt  = cnt_nxt + CW'(1);
            mode_nxt = MODE_IDLE;
          end
        end else begin
          vb       = 1'b1;
          rec_b    = mk_rec(TK_BAD, sat_index(cnt_nxt), '0, 1'b0, '0, '0, c);
          mode_nxt = MODE_DRAIN;
        end
      end
    end

    if (vb)      rec_b.last = 1'b1;
    else if (va) rec_a.last = 1'b1;
  end

  always_comb begin
    push_o.n  = accept ? ({1'b0, va} + {1'b0, vb}) : 2'd0;
    push_o.r0 = va ? rec_a : rec_b;
    push_o.r1 = rec_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cnt_r  <= '0;
      buf_r  <= '0;
      fill_r <= '0;
      acc_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      buf_r  <= buf_nxt;
      fill_r <= fill_nxt;
      acc_r  <= acc_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

FILE: rtl/core/clx_queue.sv
// ----------------------------------------------------------------------------
// clx_queue
// Result queue: takes up to two records a cycle, hands out one.
// ----------------------------------------------------------------------------
`include "c_subset_lexer_assert.svh"

module clx_queue import clx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  clx_push_t push_i,
  input  logic      pop_i,
  output logic      room_o,
  output logic      head_valid_o,
  output clx_rec_t  head_o
);

  clx_rec_t           mem_r [QDEPTH];
  logic [QPW-1:0]     wr_r, rd_r;
  logic [QPW-1:0]     wr_nxt, rd_nxt, wr_p1;
  logic [QCW-1:0]     cnt_r, cnt_nxt;

  assign wr_p1        = wr_r + QPW'(1);
  assign wr_nxt       = wr_r + QPW'(push_i.n);
  assign rd_nxt       = rd_r + QPW'(pop_i);
  assign cnt_nxt      = cnt_r + QCW'(push_i.n) - QCW'(pop_i);
  // Room for a byte's worst case of two records
  assign room_o       = cnt_r <= QCW'(QDEPTH - 2);
  assign head_valid_o = cnt_r != '0;
  assign head_o       = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push_i.n != 2'd0) mem_r[wr_r] <= push_i.r0;
    if (push_i.n == 2'd2) mem_r[wr_p1] <= push_i.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `CLX_ASSERT_IMP(a_q_no_overrun, push_i.n != 2'd0, cnt_r <= QCW'(QDEPTH - 2), "queue overrun")
  `CLX_ASSERT_IMP(a_q_pop_nonempty, pop_i, cnt_r != '0, "pop from empty queue")
  `CLX_ASSERT_NXT(a_q_hold, push_i.n == 2'd0 && !pop_i, $stable(cnt_r) && $stable(rd_r), "queue moved while idle")

endmodule

FILE: rtl/core/clx_back.sv
// ----------------------------------------------------------------------------
// clx_back
// Output stage: registers one record and holds it while the sink stalls.
// ----------------------------------------------------------------------------
module clx_back import clx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid_i,
  input  clx_rec_t head_i,
  output logic     pop_o,
  output logic     out_valid,
  input  logic     out_stall,
  output clx_rec_t rec_o
);

  logic     out_valid_r, out_valid_nxt;
  clx_rec_t rec_r;

  assign pop_o         = head_valid_i && (!out_valid_r || !out_stall);
  assign out_valid_nxt = pop_o || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;
  assign rec_o         = rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop_o) rec_r <= head_i;
  end

endmodule
